// File: hdl/tile_plane_pixel_renderer_assert.svh
// Assertion macros for the tile-plane pixel renderer.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef TILE_PLANE_PIXEL_RENDERER_ASSERT_SVH
`define TILE_PLANE_PIXEL_RENDERER_ASSERT_SVH

`ifndef ASSERT_OFF
`define TPR_ASSERT(name, prop) name: assert property (@(posedge clk_i) disable iff (!rst_ni) \
  (prop)) else $error("tile plane renderer: property failed");
`define TPR_ASSERT_NEVER(name, cond) name: assert property (@(posedge clk_i) \
  disable iff (!rst_ni) !(cond)) else $error("tile plane renderer: forbidden condition");
`else
`define TPR_ASSERT(name, prop)
`define TPR_ASSERT_NEVER(name, cond)
`endif

`endif

// File: hdl/tpr_pkg.sv
// Shared types, codes and helper functions of the tile-plane pixel renderer.
// No dependencies; imported by every module of the block except tpr_ram.
package tpr_pkg;

  typedef enum logic [1:0] {
    OP_RENDER  = 2'd0,
    OP_PALETTE = 2'd1,
    OP_PATTERN = 2'd2,
    OP_NAME    = 2'd3
  } op_e;

  localparam logic [1:0] SRC_BACKDROP = 2'd0;
  localparam logic [1:0] SRC_BG       = 2'd1;
  localparam logic [1:0] SRC_FG       = 2'd2;

  localparam logic CFG_PLANE_WIDTH = 1'b0;
  localparam logic CFG_BACKDROP    = 1'b1;

  localparam logic [6:0]  PLANE_WIDTH_RESET = 7'd40;
  localparam logic [23:0] BACKDROP_RESET    = 24'h00AAAA;

  localparam int PAL_DEPTH   = 64;
  localparam int QUEUE_DEPTH = 2;
  localparam int CELL_IDX_W  = 13;
  localparam int EFF_W_W     = 8;

  // One classified item as it travels from the front to the back.
  typedef struct packed {
    op_e         op;
    logic        hit;        // write in range, or pixel inside the plane
    logic        plane_sel;
    logic [15:0] addr;       // write address, or cell index for a render
    logic [15:0] data;
    logic [2:0]  px;
    logic [2:0]  py;
  } item_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } back_status_t;

  typedef struct packed {
    logic [15:0] addr;
    logic        odd;
    logic [1:0]  row;
  } fetch_t;

  // Cell word layout: priority, palette row (2), vflip, hflip, tile (11).
  function automatic fetch_t plane_fetch(logic [15:0] word, logic [2:0] px,
                                         logic [2:0] py);
    fetch_t     f;
    logic [2:0] fx;
    logic [2:0] fy;
    fx     = word[11] ? ~px : px;
    fy     = word[12] ? ~py : py;
    f.addr = {word[10:0], fy, fx[2:1]};
    f.odd  = fx[0];
    f.row  = word[14:13];
    return f;
  endfunction

  function automatic logic [8:0] pal_pack(logic [15:0] data);
    return {data[11:9], data[7:5], data[3:1]};
  endfunction

  function automatic logic [23:0] pal_to_rgb(logic [8:0] p);
    return {p[2:0], 5'd0, p[5:3], 5'd0, p[8:6], 5'd0};
  endfunction

endpackage

// File: hdl/tpr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module tpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/tpr_front.sv
// Front end: decodes an incoming beat and classifies it for the back end.
// Depends on tpr_pkg for the item layout and operation codes.
module tpr_front #(
  parameter int PLANE_ROWS     = 28,
  parameter int MAX_PLANE_COLS = 64,
  parameter int PATTERN_BYTES  = 65536,
  parameter int NAME_DEPTH     = 1792
) (
  input  logic [6:0]     plane_width_i,
  input  logic [1:0]     operation_i,
  input  logic           plane_select_i,
  input  logic [15:0]    address_i,
  input  logic [15:0]    write_data_i,
  input  logic [8:0]     pixel_x_i,
  input  logic [7:0]     pixel_y_i,
  output tpr_pkg::item_t item_o
);
  import tpr_pkg::*;

  localparam logic [EFF_W_W-1:0] MaxW     = EFF_W_W'(MAX_PLANE_COLS);
  localparam logic [6:0]         RowsEnd  = 7'(PLANE_ROWS);
  localparam logic [16:0]        PatEnd   = 17'(PATTERN_BYTES);
  localparam logic [16:0]        NameEnd  = 17'(NAME_DEPTH);

  logic [EFF_W_W-1:0]    w_raw;
  logic [EFF_W_W-1:0]    w_eff;
  logic [5:0]            cx;
  logic [4:0]            cy;
  logic                  in_plane;
  logic [CELL_IDX_W-1:0] cell_idx;
  op_e                   op;

  assign w_raw = {1'b0, plane_width_i};
  // A zero width acts as one cell; anything wider than the store is capped.
  assign w_eff = (plane_width_i == 7'd0) ? EFF_W_W'(1) :
                 (w_raw > MaxW) ? MaxW : w_raw;
  assign cx       = pixel_x_i[8:3];
  assign cy       = pixel_y_i[7:3];
  assign in_plane = ({2'b00, cx} < w_eff) && ({2'b00, cy} < RowsEnd);
  assign cell_idx = CELL_IDX_W'(cy) * CELL_IDX_W'(w_eff) + CELL_IDX_W'(cx);
  assign op       = op_e'(operation_i);

  always_comb begin
    item_o.op        = op;
    item_o.plane_sel = plane_select_i;
    item_o.addr      = address_i;
    item_o.data      = write_data_i;
    item_o.px        = pixel_x_i[2:0];
    item_o.py        = pixel_y_i[2:0];
    item_o.hit       = 1'b0;
    unique case (op)
      OP_RENDER: begin
        item_o.hit  = in_plane;
        item_o.addr = in_plane ? 16'(cell_idx) : 16'd0;
      end
      OP_PALETTE: item_o.hit = (address_i[15:6] == 10'd0);
      OP_PATTERN: item_o.hit = ({1'b0, address_i} < PatEnd);
      OP_NAME:    item_o.hit = ({1'b0, address_i} < NameEnd);
      default:    item_o.hit = 1'b0;
    endcase
  end

endmodule

// File: hdl/tpr_fifo.sv
// Short item queue between the front end and the back end.
// Depends on tpr_pkg for the item type.
module tpr_fifo #(
  parameter int DEPTH = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tpr_pkg::item_t item_i,
  input  logic           pop_i,
  output tpr_pkg::item_t item_o,
  output logic           empty_o,
  output logic           full_o
);
  import tpr_pkg::*;

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0]   Last = AW'(DEPTH - 1);
  localparam logic [CNTW-1:0] Full = CNTW'(DEPTH);

  item_t           mem_q [DEPTH];
  logic [AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNTW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == Last) ? '0 : wr_ptr_q + AW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == Last) ? '0 : rd_ptr_q + AW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNTW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNTW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assign item_o  = mem_q[rd_ptr_q];
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == Full);

endmodule

// File: hdl/tpr_back.sv
// Back end: owns the palette, pattern and nametable stores, performs writes
// and sequences the chained reads of a render. Depends on tpr_pkg and tpr_ram.
module tpr_back #(
  parameter int NAME_DEPTH    = 1792,
  parameter int PATTERN_BYTES = 65536
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tpr_pkg::item_t        item_i,
  input  logic                  item_valid_i,
  output logic                  item_pop_o,
  input  logic [23:0]           backdrop_rgb_i,
  output logic [23:0]           pixel_rgb_o,
  output logic [1:0]            pixel_source_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output tpr_pkg::back_status_t status_o
);
  import tpr_pkg::*;

  localparam int NameAw   = (NAME_DEPTH > 1) ? $clog2(NAME_DEPTH) : 1;
  localparam int PatAw    = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;
  localparam int ClrDepth = (PATTERN_BYTES > NAME_DEPTH) ? PATTERN_BYTES : NAME_DEPTH;
  localparam int ClrW     = $clog2(ClrDepth);
  localparam int ClrEw    = ClrW + 1;
  localparam logic [ClrW-1:0] ClrLast = ClrW'(ClrDepth - 1);
  localparam logic [ClrW:0]   NameEnd = ClrEw'(NAME_DEPTH);
  localparam logic [ClrW:0]   PatEnd  = ClrEw'(PATTERN_BYTES);
  localparam logic [ClrW:0]   PalEnd  = ClrEw'(PAL_DEPTH);
  localparam logic [16:0]     PatLim  = 17'(PATTERN_BYTES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_NAME,
    S_PFG,
    S_PBG,
    S_PAL
  } state_e;

  state_e          state_q, state_d;
  logic            clearing_q, clearing_d;
  logic [ClrW-1:0] clr_cnt_q, clr_cnt_d;
  item_t           cur_q, cur_d;
  logic            fg_ok_q, fg_ok_d;
  logic            fg_odd_q, fg_odd_d;
  logic [1:0]      fg_row_q, fg_row_d;
  logic [3:0]      fg_nib_q, fg_nib_d;
  logic            bg_ok_q, bg_ok_d;
  logic            bg_odd_q, bg_odd_d;
  logic [1:0]      bg_row_q, bg_row_d;
  logic [1:0]      sel_src_q, sel_src_d;
  logic            out_valid_q, out_valid_d;
  logic [23:0]     rgb_q, rgb_d;
  logic [1:0]      src_q, src_d;

  logic             pop;
  logic             load;
  logic [15:0]      bg_word, fg_word;
  logic [7:0]       pat_byte;
  logic [8:0]       pal_word;
  fetch_t           fg_f, bg_f;
  logic             fg_ok, bg_ok;
  logic             pat_odd;
  logic [3:0]       pat_nib;
  logic [3:0]       bg_nib;
  logic [5:0]       pal_idx;
  logic             pat_re;
  logic [PatAw-1:0] pat_raddr;

  logic              pal_we, pat_we, bgn_we, fgn_we;
  logic [5:0]        pal_waddr;
  logic [8:0]        pal_wdata;
  logic [PatAw-1:0]  pat_waddr;
  logic [7:0]        pat_wdata;
  logic [NameAw-1:0] name_waddr;
  logic [15:0]       name_wdata;
  logic [ClrW:0]     clr_ext;

  assign pop     = (state_q == S_IDLE) && !clearing_q && item_valid_i;
  assign load    = (state_q == S_PAL) && (!out_valid_q || out_ready_i);
  assign clr_ext = {1'b0, clr_cnt_q};

  // During the clearing pass every store is swept with zeros.
  always_comb begin
    if (clearing_q) begin
      pal_we     = (clr_ext < PalEnd);
      pat_we     = (clr_ext < PatEnd);
      bgn_we     = (clr_ext < NameEnd);
      fgn_we     = (clr_ext < NameEnd);
      pal_waddr  = clr_cnt_q[5:0];
      pat_waddr  = clr_cnt_q[PatAw-1:0];
      name_waddr = clr_cnt_q[NameAw-1:0];
      pal_wdata  = '0;
      pat_wdata  = '0;
      name_wdata = '0;
    end else begin
      pal_we     = pop && item_i.hit && (item_i.op == OP_PALETTE);
      pat_we     = pop && item_i.hit && (item_i.op == OP_PATTERN);
      bgn_we     = pop && item_i.hit && (item_i.op == OP_NAME) && !item_i.plane_sel;
      fgn_we     = pop && item_i.hit && (item_i.op == OP_NAME) && item_i.plane_sel;
      pal_waddr  = item_i.addr[5:0];
      pat_waddr  = item_i.addr[PatAw-1:0];
      name_waddr = item_i.addr[NameAw-1:0];
      pal_wdata  = pal_pack(item_i.data);
      pat_wdata  = item_i.data[7:0];
      name_wdata = item_i.data;
    end
  end

  assign fg_f    = plane_fetch(fg_word, cur_q.px, cur_q.py);
  assign bg_f    = plane_fetch(bg_word, cur_q.px, cur_q.py);
  assign fg_ok   = cur_q.hit && ({1'b0, fg_f.addr} < PatLim);
  assign bg_ok   = cur_q.hit && ({1'b0, bg_f.addr} < PatLim);
  assign pat_re  = (state_q == S_NAME) || (state_q == S_PFG);
  assign pat_odd = (state_q == S_PBG) ? bg_odd_q : fg_odd_q;
  assign pat_nib = pat_odd ? pat_byte[3:0] : pat_byte[7:4];
  assign bg_nib  = bg_ok_q ? pat_nib : 4'd0;

  always_comb begin
    pat_raddr = '0;
    if (state_q == S_NAME && fg_ok) begin
      pat_raddr = fg_f.addr[PatAw-1:0];
    end else if (state_q == S_PFG && bg_ok) begin
      pat_raddr = bg_f.addr[PatAw-1:0];
    end
  end

  // Foreground wins when its nibble is nonzero, then background, then backdrop.
  always_comb begin
    if (fg_nib_q != 4'd0) begin
      pal_idx   = {fg_row_q, fg_nib_q};
      sel_src_d = SRC_FG;
    end else if (bg_nib != 4'd0) begin
      pal_idx   = {bg_row_q, bg_nib};
      sel_src_d = SRC_BG;
    end else begin
      pal_idx   = '0;
      sel_src_d = SRC_BACKDROP;
    end
    if (state_q != S_PBG) begin
      sel_src_d = sel_src_q;
    end
  end

  always_comb begin
    state_d     = state_q;
    clearing_d  = clearing_q;
    clr_cnt_d   = clr_cnt_q;
    cur_d       = cur_q;
    fg_ok_d     = fg_ok_q;
    fg_odd_d    = fg_odd_q;
    fg_row_d    = fg_row_q;
    fg_nib_d    = fg_nib_q;
    bg_ok_d     = bg_ok_q;
    bg_odd_d    = bg_odd_q;
    bg_row_d    = bg_row_q;
    out_valid_d = out_valid_q && !out_ready_i;
    rgb_d       = rgb_q;
    src_d       = src_q;
    if (clearing_q) begin
      clr_cnt_d = clr_cnt_q + ClrW'(1);
      if (clr_cnt_q == ClrLast) begin
        clearing_d = 1'b0;
      end
    end
    unique case (state_q)
      S_IDLE: begin
        if (pop && item_i.op == OP_RENDER) begin
          cur_d   = item_i;
          state_d = S_NAME;
        end
      end
      S_NAME: begin
        fg_ok_d  = fg_ok;
        fg_odd_d = fg_f.odd;
        fg_row_d = fg_f.row;
        state_d  = S_PFG;
      end
      S_PFG: begin
        fg_nib_d = fg_ok_q ? pat_nib : 4'd0;
        bg_ok_d  = bg_ok;
        bg_odd_d = bg_f.odd;
        bg_row_d = bg_f.row;
        state_d  = S_PBG;
      end
      S_PBG: begin
        state_d = S_PAL;
      end
      S_PAL: begin
        if (load) begin
          out_valid_d = 1'b1;
          src_d       = sel_src_q;
          rgb_d       = (sel_src_q == SRC_BACKDROP) ? backdrop_rgb_i : pal_to_rgb(pal_word);
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      clearing_q  <= 1'b1;
      clr_cnt_q   <= '0;
      cur_q       <= '0;
      fg_ok_q     <= 1'b0;
      fg_odd_q    <= 1'b0;
      fg_row_q    <= '0;
      fg_nib_q    <= '0;
      bg_ok_q     <= 1'b0;
      bg_odd_q    <= 1'b0;
      bg_row_q    <= '0;
      sel_src_q   <= SRC_BACKDROP;
      out_valid_q <= 1'b0;
      rgb_q       <= '0;
      src_q       <= SRC_BACKDROP;
    end else begin
      state_q     <= state_d;
      clearing_q  <= clearing_d;
      clr_cnt_q   <= clr_cnt_d;
      cur_q       <= cur_d;
      fg_ok_q     <= fg_ok_d;
      fg_odd_q    <= fg_odd_d;
      fg_row_q    <= fg_row_d;
      fg_nib_q    <= fg_nib_d;
      bg_ok_q     <= bg_ok_d;
      bg_odd_q    <= bg_odd_d;
      bg_row_q    <= bg_row_d;
      sel_src_q   <= sel_src_d;
      out_valid_q <= out_valid_d;
      rgb_q       <= rgb_d;
      src_q       <= src_d;
    end
  end

  // Name reads are issued as a render leaves the queue; their data holds
  // until the next render because the read enable stays low meanwhile.
  tpr_ram #(.WIDTH(16), .DEPTH(NAME_DEPTH)) u_bg_names (
    .clk_i   (clk_i),
    .we_i    (bgn_we),
    .waddr_i (name_waddr),
    .wdata_i (name_wdata),
    .re_i    (pop && item_i.op == OP_RENDER),
    .raddr_i (item_i.addr[NameAw-1:0]),
    .rdata_o (bg_word)
  );

  tpr_ram #(.WIDTH(16), .DEPTH(NAME_DEPTH)) u_fg_names (
    .clk_i   (clk_i),
    .we_i    (fgn_we),
    .waddr_i (name_waddr),
    .wdata_i (name_wdata),
    .re_i    (pop && item_i.op == OP_RENDER),
    .raddr_i (item_i.addr[NameAw-1:0]),
    .rdata_o (fg_word)
  );

  tpr_ram #(.WIDTH(8), .DEPTH(PATTERN_BYTES)) u_patterns (
    .clk_i   (clk_i),
    .we_i    (pat_we),
    .waddr_i (pat_waddr),
    .wdata_i (pat_wdata),
    .re_i    (pat_re),
    .raddr_i (pat_raddr),
    .rdata_o (pat_byte)
  );

  tpr_ram #(.WIDTH(9), .DEPTH(PAL_DEPTH)) u_palette (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (pal_waddr),
    .wdata_i (pal_wdata),
    .re_i    (state_q == S_PBG),
    .raddr_i (pal_idx),
    .rdata_o (pal_word)
  );

  assign item_pop_o        = pop;
  assign out_valid_o       = out_valid_q;
  assign pixel_rgb_o       = rgb_q;
  assign pixel_source_o    = src_q;
  assign status_o.clearing = clearing_q;
  assign status_o.busy     = (state_q != S_IDLE);

endmodule

// File: hdl/tile_plane_pixel_renderer.sv
// Tile-plane pixel renderer top level: config registers, front end, queue, back end.
// Writes are performed as the back end pops them from the queue; a render steps through
// a chain of synchronous reads (name, two pattern reads on the single pattern port,
// palette) and then waits for the output slot. Input beats queue while the back end works.
// After reset a clearing pass zeroes all stores, sweeping every address of the
// largest store, with in_ready_o low.
`include "tile_plane_pixel_renderer_assert.svh"

module tile_plane_pixel_renderer #(
  parameter int PLANE_ROWS     = 28,
  parameter int MAX_PLANE_COLS = 64,
  parameter int PATTERN_BYTES  = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic        plane_select_i,
  input  logic [15:0] address_i,
  input  logic [15:0] write_data_i,
  input  logic [8:0]  pixel_x_i,
  input  logic [7:0]  pixel_y_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [23:0] pixel_rgb_o,
  output logic [1:0]  pixel_source_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [23:0] cfg_data_i
);
  import tpr_pkg::*;

  localparam int NameDepth = PLANE_ROWS * MAX_PLANE_COLS;

  logic [6:0]   plane_width_q;
  logic [23:0]  backdrop_q;
  item_t        front_item;
  item_t        head_item;
  logic         fifo_empty;
  logic         fifo_full;
  logic         item_pop;
  logic         push;
  back_status_t back_status;
  logic         palette_bad;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_width_q <= PLANE_WIDTH_RESET;
      backdrop_q    <= BACKDROP_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_PLANE_WIDTH: plane_width_q <= cfg_data_i[6:0];
        CFG_BACKDROP:    backdrop_q    <= cfg_data_i;
        default:         plane_width_q <= plane_width_q;
      endcase
    end
  end

  assign in_ready_o = !fifo_full && !back_status.clearing;
  assign push       = in_valid_i && in_ready_o;

  tpr_front #(
    .PLANE_ROWS     (PLANE_ROWS),
    .MAX_PLANE_COLS (MAX_PLANE_COLS),
    .PATTERN_BYTES  (PATTERN_BYTES),
    .NAME_DEPTH     (NameDepth)
  ) u_front (
    .plane_width_i  (plane_width_q),
    .operation_i    (operation_i),
    .plane_select_i (plane_select_i),
    .address_i      (address_i),
    .write_data_i   (write_data_i),
    .pixel_x_i      (pixel_x_i),
    .pixel_y_i      (pixel_y_i),
    .item_o         (front_item)
  );

  tpr_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (item_pop),
    .item_o  (head_item),
    .empty_o (fifo_empty),
    .full_o  (fifo_full)
  );

  tpr_back #(
    .NAME_DEPTH    (NameDepth),
    .PATTERN_BYTES (PATTERN_BYTES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (head_item),
    .item_valid_i   (!fifo_empty),
    .item_pop_o     (item_pop),
    .backdrop_rgb_i (backdrop_q),
    .pixel_rgb_o    (pixel_rgb_o),
    .pixel_source_o (pixel_source_o),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (back_status)
  );

  // A palette color with any bit set below the three expanded channel bits.
  assign palette_bad = (pixel_source_o != SRC_BACKDROP) &&
                       ((pixel_rgb_o[20:16] != 5'd0) || (pixel_rgb_o[12:8] != 5'd0) ||
                        (pixel_rgb_o[4:0] != 5'd0));

  // Nothing is in flight while the stores are being cleared.
  `TPR_ASSERT(a_clear_quiet, back_status.clearing |-> (fifo_empty && !out_valid_o))
  // A result only appears at the end of a render sequence.
  `TPR_ASSERT(a_result_from_render, $rose(out_valid_o) |-> $past(back_status.busy))
  // Palette colors never carry bits below the three expanded channel bits.
  `TPR_ASSERT_NEVER(a_palette_low_bits, out_valid_o && palette_bad)

endmodule
